FILE: design/drc_pkg.sv
`timescale 1ns / 1ps

package drc_pkg;

   // mode codes
   localparam logic [2:0] MODE_DISC    = 3'd0;
   localparam logic [2:0] MODE_READY   = 3'd1;
   localparam logic [2:0] MODE_DETACH  = 3'd2;
   localparam logic [2:0] MODE_PENDING = 3'd3;
   localparam logic [2:0] MODE_RECOV   = 3'd4;
   localparam logic [2:0] MODE_WAIT    = 3'd5;

   // command codes
   localparam logic [2:0] CMD_RESTART = 3'd0;
   localparam logic [2:0] CMD_REMOVED = 3'd1;
   localparam logic [2:0] CMD_ARRIVED = 3'd2;
   localparam logic [2:0] CMD_NEXT    = 3'd3;
   localparam logic [2:0] CMD_DETACHED = 3'd4;
   localparam logic [2:0] CMD_ATTACH  = 3'd5;
   localparam logic [2:0] CMD_STATUS  = 3'd6;

   // action codes
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_DETACH = 2'd1;
   localparam logic [1:0] ACT_ATTACH = 2'd2;

   // register indexes
   localparam logic [2:0] REG_MATCH_PID      = 3'd0;
   localparam logic [2:0] REG_START_READY    = 3'd1;
   localparam logic [2:0] REG_RETRY_DELAY_MS = 3'd2;
   localparam logic [2:0] REG_RETRY_LIMIT    = 3'd3;
   localparam logic [2:0] REG_DETACH_WAIT_MS = 3'd4;

   localparam logic [31:0] WAIT_NONE = 32'hFFFF_FFFF;
   localparam logic [63:0] WAIT_MAX  = 64'd2147483647;

   typedef struct packed {
      logic [15:0] match_pid;
      logic        start_ready;
      logic [15:0] retry_delay_ms;
      logic [7:0]  retry_limit;
      logic [15:0] detach_wait_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       dev_seen;
      logic [7:0] fail_cnt;
   } ctl_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] wait_ms;
      logic        is_ready;
      logic        is_retrying;
   } rsp_type;

endpackage

FILE: design/device_reconnect_controller.sv
`timescale 1ns / 1ps

// Hot-plug recovery controller for one expected device. Each request carries a
// command in req_tuser (restart, removed, arrived, next action, detached,
// attach result, status) and returns exactly one response: the action to take,
// the wait in ms until the next poll (-1 for none) and the ready and retrying
// flags, all as they stand after the command. A request is registered on
// acceptance and applied against the controller state; the new state and the
// response load when the response register is free or drains, so one request
// can be accepted every cycle while rsp_tready stays high. The single state
// update (one add, one subtract and a few compares over TIME_BITS) sets the
// cycle. Configuration is written through csr_we/csr_index/csr_wdata; the user
// must write it only while no request is in flight; not enforced by the block.
module device_reconnect_controller #(
   parameter int TIME_BITS = 48
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: product_id[15:0], attach_ok, now_ms[TIME_BITS-1:0], zero fill
   input  logic [((17+TIME_BITS+7)/8)*8-1:0]      req_tdata,
   // tuser: command[2:0]
   input  logic [2:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: action[1:0], wait_ms[31:0], is_ready, is_retrying, zero fill
   output logic [39:0]                            rsp_tdata,
   input  logic                                   csr_we,
   input  logic [2:0]                             csr_index,
   input  logic [15:0]                            csr_wdata
);
   import drc_pkg::*;

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // controller state
   ctl_type              ctl_ff;
   ctl_type              ctl_in;
   logic [TIME_BITS-1:0] deadline_ff;
   logic [TIME_BITS-1:0] deadline_in;

   // request register
   logic                 req_vld_ff;
   logic [2:0]           cmd_ff;
   logic [15:0]          prod_ff;
   logic                 ok_ff;
   logic [TIME_BITS-1:0] now_ff;

   // response register
   logic    rsp_vld_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic req_take;
   logic advance;

   // Advance the held request whenever the response register is free or drains.
   assign advance    = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MATCH_PID:      cfg_in.match_pid      = csr_wdata;
            REG_START_READY:    cfg_in.start_ready    = csr_wdata[0];
            REG_RETRY_DELAY_MS: cfg_in.retry_delay_ms = csr_wdata;
            REG_RETRY_LIMIT:    cfg_in.retry_limit    = csr_wdata[7:0];
            REG_DETACH_WAIT_MS: cfg_in.detach_wait_ms = csr_wdata;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_pid      <= '0;
         cfg_ff.start_ready    <= 1'b0;
         cfg_ff.retry_delay_ms <= 16'd500;
         cfg_ff.retry_limit    <= 8'd10;
         cfg_ff.detach_wait_ms <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Capture the request fields; hold them while the request waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_tready) begin
         req_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_tuser;
         prod_ff <= req_tdata[15:0];
         ok_ff   <= req_tdata[16];
         now_ff  <= req_tdata[17 +: TIME_BITS];
      end
   end

   // Apply the held request against the controller state.
   drc_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg          (cfg_ff),
      .ctl_cur      (ctl_ff),
      .deadline_cur (deadline_ff),
      .command      (cmd_ff),
      .product_id   (prod_ff),
      .attach_ok    (ok_ff),
      .now_ms       (now_ff),
      .ctl_nxt      (ctl_in),
      .deadline_nxt (deadline_in),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.mode     <= MODE_DISC;
         ctl_ff.dev_seen <= 1'b0;
         ctl_ff.fail_cnt <= '0;
         deadline_ff     <= '0;
      end else if (advance) begin
         ctl_ff      <= ctl_in;
         deadline_ff <= deadline_in;
      end
   end

   // Response register: load on advance, clear valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.is_retrying, rsp_ff.is_ready,
                        rsp_ff.wait_ms, rsp_ff.action};

   // assertions
   assert property (@(posedge clock) disable iff (reset)
      ctl_ff.mode <= MODE_WAIT)
      else $error("controller mode left the defined codes");

   assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.mode == MODE_READY || ctl_ff.mode == MODE_PENDING) |-> ctl_ff.dev_seen)
      else $error("ready or pending without an arrival seen");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_ff.is_ready && rsp_ff.is_retrying))
      else $error("response flags ready and retrying both set");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.action != ACT_NONE) |->
         (rsp_ff.action == ACT_DETACH || rsp_ff.action == ACT_ATTACH))
      else $error("undefined action code in response");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.action == ACT_DETACH) |-> ctl_ff.mode == MODE_DETACH
         || $past(advance) == 1'b0 || $past(req_vld_ff))
      else $error("detach action reported outside detaching");

   assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && !advance) |=> (req_vld_ff && $stable(cmd_ff) && $stable(now_ff)))
      else $error("stalled request register lost its contents");

endmodule

FILE: design/drc_step.sv
`timescale 1ns / 1ps

module drc_step #(
   parameter int TIME_BITS = 48
) (
   input  drc_pkg::cfg_type       cfg,
   input  drc_pkg::ctl_type       ctl_cur,
   input  logic [TIME_BITS-1:0]   deadline_cur,
   input  logic [2:0]             command,
   input  logic [15:0]            product_id,
   input  logic                   attach_ok,
   input  logic [TIME_BITS-1:0]   now_ms,
   output drc_pkg::ctl_type       ctl_nxt,
   output logic [TIME_BITS-1:0]   deadline_nxt,
   output drc_pkg::rsp_type       rsp
);
   import drc_pkg::*;

   logic                 match;
   logic                 due;
   logic [TIME_BITS:0]   dl_sum;
   logic [TIME_BITS-1:0] dl_sat;
   logic [7:0]           cnt_inc;
   logic [TIME_BITS-1:0] rem;
   logic [63:0]          rem64;
   logic                 due_nxt;
   logic [1:0]           act_nxt;
   logic [31:0]          wait_nxt;

   assign match   = (product_id == cfg.match_pid);
   assign due     = (now_ms >= deadline_cur);
   assign dl_sum  = {1'b0, now_ms} + (TIME_BITS+1)'(cfg.retry_delay_ms);
   assign dl_sat  = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
   assign cnt_inc = (ctl_cur.fail_cnt == 8'hFF) ? ctl_cur.fail_cnt
                                                : ctl_cur.fail_cnt + 8'd1;

   always_comb begin
      ctl_nxt      = ctl_cur;
      deadline_nxt = deadline_cur;
      act_nxt      = ACT_NONE;
      unique case (command)
         CMD_RESTART: begin
            ctl_nxt.mode     = cfg.start_ready ? MODE_READY : MODE_DISC;
            ctl_nxt.dev_seen = cfg.start_ready;
            ctl_nxt.fail_cnt = '0;
            deadline_nxt     = '0;
         end
         CMD_REMOVED: begin
            if (match && (ctl_cur.mode == MODE_READY || ctl_cur.mode == MODE_RECOV)) begin
               ctl_nxt.mode     = MODE_DETACH;
               ctl_nxt.dev_seen = 1'b0;
               deadline_nxt     = '0;
            end
         end
         CMD_ARRIVED: begin
            if (match) begin
               ctl_nxt.dev_seen = 1'b1;
               if (ctl_cur.mode == MODE_DISC || ctl_cur.mode == MODE_WAIT) begin
                  ctl_nxt.fail_cnt = '0;
                  ctl_nxt.mode     = MODE_PENDING;
               end
            end
         end
         CMD_NEXT: begin
            if (ctl_cur.mode == MODE_DETACH) begin
               act_nxt = ACT_DETACH;
            end else if (ctl_cur.mode == MODE_PENDING ||
                         (ctl_cur.mode == MODE_WAIT && ctl_cur.dev_seen && due)) begin
               ctl_nxt.mode = MODE_RECOV;
               act_nxt      = ACT_ATTACH;
            end
         end
         CMD_DETACHED: begin
            ctl_nxt.mode = ctl_cur.dev_seen ? MODE_PENDING : MODE_DISC;
         end
         CMD_ATTACH: begin
            if (attach_ok) begin
               ctl_nxt.mode     = MODE_READY;
               ctl_nxt.dev_seen = 1'b1;
               ctl_nxt.fail_cnt = '0;
               deadline_nxt     = '0;
            end else begin
               ctl_nxt.fail_cnt = cnt_inc;
               if (cnt_inc >= cfg.retry_limit) begin
                  ctl_nxt.mode     = MODE_DISC;
                  ctl_nxt.dev_seen = 1'b0;
                  deadline_nxt     = '0;
               end else begin
                  ctl_nxt.mode = MODE_WAIT;
                  deadline_nxt = dl_sat;
               end
            end
         end
         default: begin
            // status and the unused code change nothing
         end
      endcase
   end

   // wait until next poll, taken after the event
   assign due_nxt = (now_ms >= deadline_nxt);
   assign rem     = deadline_nxt - now_ms;
   assign rem64   = 64'(rem);

   always_comb begin
      if (ctl_nxt.mode == MODE_DETACH) begin
         wait_nxt = 32'(cfg.detach_wait_ms);
      end else if (ctl_nxt.mode != MODE_WAIT || !ctl_nxt.dev_seen) begin
         wait_nxt = WAIT_NONE;
      end else if (due_nxt) begin
         wait_nxt = '0;
      end else if (rem64 > WAIT_MAX) begin
         wait_nxt = WAIT_MAX[31:0];
      end else begin
         wait_nxt = rem64[31:0];
      end
   end

   assign rsp = {act_nxt, wait_nxt, (ctl_nxt.mode == MODE_READY),
                 (ctl_nxt.mode == MODE_WAIT)};

endmodule
